// ===== rtl/triangle_point_locator_unit_assert.svh =====
// Assertion macros used by the triangle point locator back end.
`ifndef TRIANGLE_POINT_LOCATOR_UNIT_ASSERT_SVH
`define TRIANGLE_POINT_LOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define TPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tpl_pkg.sv =====
// Shared constants and types of the triangle point locator.
package tpl_pkg;

    localparam int MAX_TRIANGLES = 1024;
    localparam int COORD_BITS    = 24;
    localparam int SLOT_BITS     = 10;
    localparam int TRI_NUM_BITS  = 10;
    localparam int COUNT_BITS    = 11;
    localparam int QUEUE_DEPTH   = 2;

    // Tolerance 1/100000 applied as integer scale factors
    localparam int TOL_K  = 100000;
    localparam int TOL_K1 = 100001;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Head of the front queue as seen by the back end
    typedef struct packed {
        logic valid;
        logic is_query;
    } t_q_ctl;

endpackage

// ===== rtl/tpl_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
interface tpl_in_if #(parameter int CW = tpl_pkg::COORD_BITS);
    logic                                 valid;
    logic                                 ready;
    logic                                 op;
    logic [tpl_pkg::SLOT_BITS-1:0]        slot;
    logic signed [CW-1:0]                 a_x;
    logic signed [CW-1:0]                 a_y;
    logic signed [CW-1:0]                 a_z;
    logic signed [CW-1:0]                 b_x;
    logic signed [CW-1:0]                 b_y;
    logic signed [CW-1:0]                 b_z;
    logic signed [CW-1:0]                 c_x;
    logic signed [CW-1:0]                 c_y;
    logic signed [CW-1:0]                 c_z;
    modport source (output valid, op, slot, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    input ready);
    modport sink   (input valid, op, slot, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    output ready);
endinterface

interface tpl_out_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic [tpl_pkg::TRI_NUM_BITS-1:0]  triangle_number;
    logic                              contained;
    modport source (output valid, found, triangle_number, contained, input ready);
    modport sink   (input valid, found, triangle_number, contained, output ready);
endinterface

interface tpl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tpl_pkg::COUNT_BITS-1:0]  data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/tpl_front.sv =====
// Front end: accepts items, drops out-of-range loads, queues the rest.
module tpl_front #(
    parameter int MAX_TRIANGLES = tpl_pkg::MAX_TRIANGLES,
    parameter int COORD_BITS    = tpl_pkg::COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tpl_in_if.sink                i_in,
    output tpl_pkg::t_q_ctl       o_q,
    output logic [9*COORD_BITS+tpl_pkg::SLOT_BITS-1:0] o_q_data,
    input  logic                  i_q_pop
);
    localparam int DW = 9*COORD_BITS + tpl_pkg::SLOT_BITS;

    logic [DW-1:0] r_data [tpl_pkg::QUEUE_DEPTH];
    logic          r_kind [tpl_pkg::QUEUE_DEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          accept, drop, push, pop;
    logic [DW-1:0] in_data;

    // Classify: a load beyond the table is taken and discarded
    assign drop    = (i_in.op == tpl_pkg::OP_LOAD) &&
                     (32'(i_in.slot) >= 32'(MAX_TRIANGLES));
    assign i_in.ready = (r_cnt != 2'(tpl_pkg::QUEUE_DEPTH));
    assign accept  = i_in.valid && i_in.ready;
    assign push    = accept && !drop;
    assign pop     = i_q_pop && (r_cnt != 2'd0);
    assign in_data = {i_in.c_z, i_in.c_y, i_in.c_x, i_in.b_z, i_in.b_y, i_in.b_x,
                      i_in.a_z, i_in.a_y, i_in.a_x, i_in.slot};

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wp] <= in_data;
            r_kind[r_wp] <= i_in.op;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assign o_q.valid    = (r_cnt != 2'd0);
    assign o_q.is_query = (r_kind[r_rp] == tpl_pkg::OP_QUERY);
    assign o_q_data     = r_data[r_rp];

endmodule

// ===== rtl/tpl_back.sv =====
// Back end: triangle store, containment scan and nearest-centroid scan.
`include "triangle_point_locator_unit_assert.svh"
module tpl_back #(
    parameter int MAX_TRIANGLES = tpl_pkg::MAX_TRIANGLES,
    parameter int COORD_BITS    = tpl_pkg::COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tpl_pkg::t_q_ctl       i_q,
    input  logic [9*COORD_BITS+tpl_pkg::SLOT_BITS-1:0] i_q_data,
    output logic                  o_q_pop,
    tpl_cfg_if.sink               i_cfg,
    tpl_out_if.source             o_out
);
    localparam int CW   = COORD_BITS;
    localparam int AW   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int NW   = $clog2(MAX_TRIANGLES + 1);
    localparam int EW   = CW + 1;          // edge component
    localparam int PW   = 2*EW;            // edge product
    localparam int XW   = PW + 1;          // cross product
    localparam int SW   = XW + 19;         // tolerance-scaled terms
    localparam int GW   = CW + 3;          // 3p - (a+b+c)
    localparam int QW   = 2*GW;            // squared component
    localparam int DSW  = QW + 2;          // squared distance
    localparam int MW   = 9*CW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_DIFF  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_CROSS = 4'd4;
    localparam logic [3:0] S_TEST  = 4'd5;
    localparam logic [3:0] S_EVAL  = 4'd6;
    localparam logic [3:0] S_CRD   = 4'd7;
    localparam logic [3:0] S_CDIFF = 4'd8;
    localparam logic [3:0] S_CMUL  = 4'd9;
    localparam logic [3:0] S_CSUM  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]            r_state;
    logic [NW-1:0]         r_n, r_idx, r_best_idx;
    logic [MW-1:0]         mem [MAX_TRIANGLES];
    logic [MW-1:0]         r_rdata;
    logic signed [CW-1:0]  r_px, r_py, r_pz;
    logic signed [CW-1:0]  t [9];
    logic signed [EW-1:0]  r_e0x, r_e0z, r_e1x, r_e1z, r_e2x, r_e2z;
    logic signed [PW-1:0]  r_m [6];
    logic signed [XW-1:0]  r_d, r_u, r_v;
    logic                  r_dzero, r_hit, r_first;
    logic signed [XW-1:0]  cd, cu, cv;
    logic signed [SW-1:0]  t0, t1, t2;
    logic signed [GW-1:0]  r_gx, r_gy, r_gz;
    logic signed [QW-1:0]  r_sx, r_sy, r_sz;
    logic [DSW-1:0]        r_best, cur_dist;
    logic                  better, last;
    logic                  r_res_found, r_res_contained;
    logic [tpl_pkg::TRI_NUM_BITS-1:0] r_res_num;
    logic                  r_ovalid, r_ofound, r_ocont;
    logic [tpl_pkg::TRI_NUM_BITS-1:0] r_onum;
    logic                  mem_we, out_load;

    // Unpack the registered read word into coordinates
    always_comb begin
        for (int k = 0; k < 9; k++) t[k] = $signed(r_rdata[k*CW +: CW]);
    end

    // Triangle store: written by loads, read at the scan index
    assign mem_we = (r_state == S_IDLE) && i_q.valid && !i_q.is_query;
    always_ff @(posedge i_clk) begin
        if (mem_we)
            mem[AW'(i_q_data[tpl_pkg::SLOT_BITS-1:0])] <= i_q_data[tpl_pkg::SLOT_BITS +: MW];
        r_rdata <= mem[r_idx[AW-1:0]];
    end

    // Triangle count register, clamped to the table size
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (i_cfg.valid) begin
            if (32'(i_cfg.data) > 32'(MAX_TRIANGLES)) r_n <= NW'(MAX_TRIANGLES);
            else                                      r_n <= NW'(i_cfg.data);
        end
    end

    // Cross products, sign-normalized
    always_comb begin
        cd = XW'(r_m[0]) - XW'(r_m[1]);
        cu = XW'(r_m[2]) - XW'(r_m[3]);
        cv = XW'(r_m[4]) - XW'(r_m[5]);
        if (cd[XW-1]) begin
            cd = -cd;
            cu = -cu;
            cv = -cv;
        end
    end

    // Tolerance tests scaled by the determinant
    always_comb begin
        t0 = SW'(r_u) * SW'(tpl_pkg::TOL_K) + SW'(r_d);
        t1 = SW'(r_v) * SW'(tpl_pkg::TOL_K) + SW'(r_d);
        t2 = SW'(r_d) * SW'(tpl_pkg::TOL_K1) - (SW'(r_u) + SW'(r_v)) * SW'(tpl_pkg::TOL_K);
    end

    // Centroid distance, scaled by nine
    assign cur_dist = DSW'($unsigned(r_sx)) + DSW'($unsigned(r_sy)) + DSW'($unsigned(r_sz));
    assign better   = r_first || (cur_dist < r_best);
    assign last     = (r_idx + NW'(1)) == r_n;

    assign o_q_pop  = (r_state == S_IDLE) && i_q.valid;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || o_out.ready);

    // Scan sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_first <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q.valid && i_q.is_query) begin
                        r_px  <= $signed(i_q_data[tpl_pkg::SLOT_BITS +: CW]);
                        r_py  <= $signed(i_q_data[tpl_pkg::SLOT_BITS + CW +: CW]);
                        r_pz  <= $signed(i_q_data[tpl_pkg::SLOT_BITS + 2*CW +: CW]);
                        r_idx <= '0;
                        if (r_n == '0) begin
                            r_res_found     <= 1'b0;
                            r_res_num       <= '0;
                            r_res_contained <= 1'b0;
                            r_state         <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD:  r_state <= S_DIFF;
                S_DIFF: begin
                    r_e0x   <= EW'(t[6]) - EW'(t[0]);
                    r_e0z   <= EW'(t[8]) - EW'(t[2]);
                    r_e1x   <= EW'(t[3]) - EW'(t[0]);
                    r_e1z   <= EW'(t[5]) - EW'(t[2]);
                    r_e2x   <= EW'(r_px) - EW'(t[0]);
                    r_e2z   <= EW'(r_pz) - EW'(t[2]);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_m[0]  <= r_e0x * r_e1z;
                    r_m[1]  <= r_e0z * r_e1x;
                    r_m[2]  <= r_e2x * r_e1z;
                    r_m[3]  <= r_e2z * r_e1x;
                    r_m[4]  <= r_e0x * r_e2z;
                    r_m[5]  <= r_e0z * r_e2x;
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    r_d     <= cd;
                    r_u     <= cu;
                    r_v     <= cv;
                    r_dzero <= (cd == '0);
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    r_hit   <= !r_dzero && !t0[SW-1] && !t1[SW-1] && !t2[SW-1];
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_hit) begin
                        r_res_found     <= 1'b1;
                        r_res_num       <= tpl_pkg::TRI_NUM_BITS'(r_idx);
                        r_res_contained <= 1'b1;
                        r_state         <= S_OUT;
                    end else if (last) begin
                        r_idx   <= '0;
                        r_first <= 1'b1;
                        r_state <= S_CRD;
                    end else begin
                        r_idx   <= r_idx + NW'(1);
                        r_state <= S_RD;
                    end
                end
                S_CRD: r_state <= S_CDIFF;
                S_CDIFF: begin
                    r_gx <= GW'(r_px) + GW'(r_px) + GW'(r_px)
                            - (GW'(t[0]) + GW'(t[3]) + GW'(t[6]));
                    r_gy <= GW'(r_py) + GW'(r_py) + GW'(r_py)
                            - (GW'(t[1]) + GW'(t[4]) + GW'(t[7]));
                    r_gz <= GW'(r_pz) + GW'(r_pz) + GW'(r_pz)
                            - (GW'(t[2]) + GW'(t[5]) + GW'(t[8]));
                    r_state <= S_CMUL;
                end
                S_CMUL: begin
                    r_sx    <= r_gx * r_gx;
                    r_sy    <= r_gy * r_gy;
                    r_sz    <= r_gz * r_gz;
                    r_state <= S_CSUM;
                end
                S_CSUM: begin
                    r_first <= 1'b0;
                    if (better) begin
                        r_best     <= cur_dist;
                        r_best_idx <= r_idx;
                    end
                    if (last) begin
                        r_res_found     <= 1'b1;
                        r_res_num       <= better ? tpl_pkg::TRI_NUM_BITS'(r_idx)
                                                  : tpl_pkg::TRI_NUM_BITS'(r_best_idx);
                        r_res_contained <= 1'b0;
                        r_state         <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + NW'(1);
                        r_state <= S_CRD;
                    end
                end
                S_OUT: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ofound <= r_res_found;
            r_onum   <= r_res_num;
            r_ocont  <= r_res_contained;
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.found           = r_ofound;
    assign o_out.triangle_number = r_onum;
    assign o_out.contained       = r_ocont;

    // Checks
    `TPL_ASSERT_NOW(a_idx_in_range, i_clk, i_rst_n,
        (r_state != S_IDLE && r_state != S_OUT), (r_idx < r_n), "scan index beyond count")
    `TPL_ASSERT_NOW(a_notfound_clean, i_clk, i_rst_n,
        (r_ovalid && !r_ofound), (!r_ocont && r_onum == '0), "not-found result not clean")
    `TPL_ASSERT_NEXT(a_no_pop_busy, i_clk, i_rst_n,
        (o_q_pop && i_q.is_query && r_n != '0), (r_state == S_RD), "query did not start scan")

endmodule

// ===== rtl/triangle_point_locator_unit.sv =====
// Scan order: a query is first tested for containment against the N triangles in use
//   (states RD, DIFF, MUL, CROSS, TEST, EVAL per triangle), then, if none holds the point,
//   for the nearest centroid (CRD, CDIFF, CMUL, CSUM per triangle); one store read port serves both.
// Throughput: one query at a time; the containment scan stops at the first hit, an empty
//   table goes straight to the result; a load is written only while the back end is idle.
// Reset: synchronous active low; clears count, queue and sequencer; store undefined.
module triangle_point_locator_unit #(
    parameter int MAX_TRIANGLES = tpl_pkg::MAX_TRIANGLES,
    parameter int COORD_BITS    = tpl_pkg::COORD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpl_in_if.sink     i_in,
    tpl_cfg_if.sink    i_cfg,
    tpl_out_if.source  o_out
);
    tpl_pkg::t_q_ctl q_ctl;
    logic [9*COORD_BITS+tpl_pkg::SLOT_BITS-1:0] q_data;
    logic            q_pop;

    tpl_front #(.MAX_TRIANGLES(MAX_TRIANGLES), .COORD_BITS(COORD_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_q      (q_ctl),
        .o_q_data (q_data),
        .i_q_pop  (q_pop)
    );

    tpl_back #(.MAX_TRIANGLES(MAX_TRIANGLES), .COORD_BITS(COORD_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q      (q_ctl),
        .i_q_data (q_data),
        .o_q_pop  (q_pop),
        .i_cfg    (i_cfg),
        .o_out    (o_out)
    );

endmodule
